// ----- sv/hpcl_pkg.sv -----
// Shared constants, register indexes and types of the hard-pair contrastive loss block.
package hpcl_pkg;

  localparam int DEF_MAX_SAMPLES = 64;
  localparam int DEF_MAX_DIM     = 128;

  localparam int FEAT_W   = 16;
  localparam int LABEL_W  = 8;
  localparam int LOSS_W   = 48;
  localparam int KEPT_W   = 11;
  localparam int DIM_W    = 8;
  localparam int MARGIN_W = 32;
  localparam int SUM_W    = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_POS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HARD_NEG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEGACY   = 3'd4;

  localparam logic [DIM_W-1:0]    RST_DIM      = 8'd128;
  localparam logic [MARGIN_W-1:0] RST_MARGIN   = 32'd65536;
  localparam logic [KEPT_W-1:0]   RST_HARD_POS = 11'd64;
  localparam logic [KEPT_W-1:0]   RST_HARD_NEG = 11'd64;

  // control bits that travel alongside a value through the root chain
  typedef struct packed {
    logic valid;
    logic tag;    // threshold value, pushed last
  } sqc_ctl_t;

endpackage

// ----- sv/hpcl_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module hpcl_ram
  import hpcl_pkg::*;
#(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- sv/hpcl_sqrt_cell.sv -----
// One cell of the integer square-root chain: resolves one root bit per cycle.
module hpcl_sqrt_cell
  import hpcl_pkg::*;
#(
  parameter int RW     = 28,
  parameter int RADP_W = 56,
  localparam int REM_W = RW + 3
) (
  input  logic              clk,
  input  logic              rst,
  input  sqc_ctl_t          in_ctl,
  input  logic [REM_W-1:0]  in_rem,
  input  logic [RW-1:0]     in_root,
  input  logic [RADP_W-1:0] in_rad,
  output sqc_ctl_t          out_ctl,
  output logic [REM_W-1:0]  out_rem,
  output logic [RW-1:0]     out_root,
  output logic [RADP_W-1:0] out_rad
);

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  always_comb begin
    rem_sh = {in_rem[REM_W-3:0], in_rad[RADP_W-1 -: 2]};
    trial  = REM_W'({in_root, 2'b01});
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl <= '0;
    end else begin
      out_ctl <= in_ctl;
    end
    out_rem  <= fits ? (rem_sh - trial) : rem_sh;
    out_root <= {in_root[RW-2:0], fits};
    out_rad  <= {in_rad[RADP_W-3:0], 2'b00};
  end

endmodule

// ----- sv/hard_pair_contrastive_loss_core.sv -----
// Hard-pair contrastive loss core: batch load, pair distances, hard-pair selection, loss.
//
// Components stream in one beat per cycle while the block is loading; the beat
// with batch_end closes the batch and the block stalls its input until the
// result beat is registered. The close runs, in order: the single
// multiply-accumulate fed by two read ports of the feature memory; the
// bitwise threshold search, one sweep of the two distance memories per
// distance bit of DIST_W (39 bits at MAX_DIM 128), that finds the k-th largest
// positive and k-th smallest negative distance; then one sweep sums the kept
// pairs while negatives go, outside legacy mode, through a chain of RW
// square-root cells (RW the root width), one root bit per cell and cycle,
// and a restoring divider scales by 2*(pairs kept). Ties at the threshold are
// counted in by multiplication. No memory needs clearing after reset. A finished
// result waits in the output register while the next batch loads.
module hard_pair_contrastive_loss_core
  import hpcl_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
  parameter int MAX_DIM     = DEF_MAX_DIM
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic signed [FEAT_W-1:0] feature,
  input  logic [LABEL_W-1:0]      label,
  input  logic                    batch_end,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [LOSS_W-1:0]       loss,
  output logic [KEPT_W-1:0]       pos_kept,
  output logic [KEPT_W-1:0]       neg_kept,
  output logic                    fault
);

  localparam int SAMP_W     = $clog2(MAX_SAMPLES + 1);
  localparam int SIDX_W     = $clog2(MAX_SAMPLES);
  localparam int DIMC_W     = $clog2(MAX_DIM + 1);
  localparam int CIDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int FEAT_DEPTH = MAX_SAMPLES * MAX_DIM;
  localparam int FADDR_W    = $clog2(FEAT_DEPTH);
  localparam int MAX_PAIRS  = MAX_SAMPLES * (MAX_SAMPLES - 1) / 2;
  localparam int PCNT_W     = $clog2(MAX_PAIRS + 1);
  localparam int PADDR_W    = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int KW         = (PCNT_W > KEPT_W) ? PCNT_W : KEPT_W;
  localparam int DIST_W     = 32 + $clog2(MAX_DIM);
  localparam int SB_W       = $clog2(DIST_W);
  localparam int RAD_W      = DIST_W + 16;
  localparam int RW         = (RAD_W + 1) / 2;
  localparam int RADP_W     = 2 * RW;
  localparam int REM_W      = RW + 3;
  localparam int DV_W       = KW + 2;
  localparam int DC_W       = $clog2(SUM_W);

  typedef enum logic [11:0] {
    ST_LOAD   = 12'b000000000001,
    ST_DIST   = 12'b000000000010,
    ST_DRAIN  = 12'b000000000100,
    ST_SCAN   = 12'b000000001000,
    ST_DECIDE = 12'b000000010000,
    ST_SUM    = 12'b000000100000,
    ST_TAIL   = 12'b000001000000,
    ST_HINGE  = 12'b000010000000,
    ST_MUL    = 12'b000100000000,
    ST_TOTAL  = 12'b001000000000,
    ST_DIV    = 12'b010000000000,
    ST_DONE   = 12'b100000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [DIM_W-1:0]    dim;
  logic [MARGIN_W-1:0] margin;
  logic [KEPT_W-1:0]   hard_pos;
  logic [KEPT_W-1:0]   hard_neg;
  logic                legacy_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim         <= RST_DIM;
      margin      <= RST_MARGIN;
      hard_pos    <= RST_HARD_POS;
      hard_neg    <= RST_HARD_NEG;
      legacy_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DIM:      dim         <= cfg_data[DIM_W-1:0];
        CFG_MARGIN:   margin      <= cfg_data[MARGIN_W-1:0];
        CFG_HARD_POS: hard_pos    <= cfg_data[KEPT_W-1:0];
        CFG_HARD_NEG: hard_neg    <= cfg_data[KEPT_W-1:0];
        CFG_LEGACY:   legacy_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // dim 0 acts as 1, anything above MAX_DIM is clamped
  logic [DIMC_W-1:0] d_eff;
  always_comb begin
    if (dim == '0) begin
      d_eff = DIMC_W'(1);
    end else if (32'(dim) > MAX_DIM) begin
      d_eff = DIMC_W'(MAX_DIM);
    end else begin
      d_eff = DIMC_W'(dim);
    end
  end

  function automatic logic [FADDR_W-1:0] faddr(input logic [SIDX_W-1:0] s,
                                                input logic [CIDX_W-1:0] c);
    faddr = FADDR_W'(s) * FADDR_W'(MAX_DIM) + FADDR_W'(c);
  endfunction

  // ---------------------------------------------------------------- load
  logic              item_accept;
  logic [SAMP_W-1:0] sc, sc0, num_r;
  logic [DIMC_W-1:0] cc, cc0, cc1, last_len;
  logic              ld_write, ld_close;

  assign item_stall  = (state != ST_LOAD);
  assign item_accept = item_valid && !item_stall;

  always_comb begin
    cc0 = cc;
    sc0 = sc;
    // dim lowered below the running count: the sample is closed first
    if (cc >= d_eff) begin
      cc0 = '0;
      if (sc < SAMP_W'(MAX_SAMPLES)) begin
        sc0 = sc + 1'b1;
      end
    end
    ld_write = item_accept && (sc0 < SAMP_W'(MAX_SAMPLES));
    cc1      = cc0 + 1'b1;
    ld_close = (cc1 >= d_eff) || batch_end;
  end

  // ---------------------------------------------------------------- memories
  logic [FADDR_W-1:0]      fa_raddr, fb_raddr;
  logic [FEAT_W-1:0]       feat_a, feat_b;
  logic [SIDX_W-1:0]       pi, pj;
  logic [CIDX_W-1:0]       pc;
  logic [LABEL_W-1:0]      lab_a, lab_b;

  assign fa_raddr = faddr(pi, pc);
  assign fb_raddr = faddr(pj, pc);

  hpcl_ram #(.WIDTH(FEAT_W), .DEPTH(FEAT_DEPTH)) u_feat_ram (
    .clk     (clk),
    .we      (ld_write),
    .waddr   (faddr(sc0[SIDX_W-1:0], cc0[CIDX_W-1:0])),
    .wdata   (feature),
    .raddr_a (fa_raddr),
    .raddr_b (fb_raddr),
    .rdata_a (feat_a),
    .rdata_b (feat_b)
  );

  hpcl_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_SAMPLES)) u_label_ram (
    .clk     (clk),
    .we      (ld_write && (cc0 == '0)),
    .waddr   (sc0[SIDX_W-1:0]),
    .wdata   (label),
    .raddr_a (pi),
    .raddr_b (pj),
    .rdata_a (lab_a),
    .rdata_b (lab_b)
  );

  // ---------------------------------------------------------------- distance pipe
  logic dist_last_c, j_last, i_last;
  logic s1_valid, s1_first, s1_last, s1_mask;
  logic s2_valid, s2_first, s2_last, s2_pos;
  logic [31:0] s2_sq;
  logic signed [FEAT_W:0] diff;
  logic signed [2*FEAT_W+1:0] sq_full;
  logic [FEAT_W-1:0] fb_eff;
  logic [DIST_W-1:0] acc, acc_sum;
  logic [PCNT_W-1:0] np, nn;

  always_comb begin
    dist_last_c = (DIMC_W'(pc) == d_eff - 1'b1);
    j_last      = (SAMP_W'(pj) == num_r - 1'b1);
    i_last      = (SAMP_W'(pi) == num_r - SAMP_W'(2));
    // tail of a short last sample reads as zero
    fb_eff      = s1_mask ? '0 : feat_b;
    diff        = {feat_a[FEAT_W-1], feat_a} - {fb_eff[FEAT_W-1], fb_eff};
    sq_full     = diff * diff;
    acc_sum     = (s2_first ? '0 : acc) + DIST_W'(s2_sq);
  end

  logic dist_we;
  assign dist_we = s2_valid && s2_last;

  // ---------------------------------------------------------------- selection
  logic [PCNT_W-1:0]  sidx, scan_n, cnt_p, cnt_n, cgt_p, cgt_n;
  logic [DIST_W-1:0]  pos_rd, neg_rd, tp, tn, bitmask, cand_p, cand_n;
  logic [SB_W-1:0]    sb;
  logic [KW-1:0]      kp, kn;
  logic               rv_valid, rv_p, rv_n;
  logic [SUM_W-1:0]   sum_p, sum_n;
  logic [DIST_W-1:0]  margin_ext;

  assign margin_ext = DIST_W'(margin);
  assign bitmask    = DIST_W'(1) << sb;
  assign cand_p     = tp | bitmask;
  assign cand_n     = tn | (bitmask - 1'b1);

  hpcl_ram #(.WIDTH(DIST_W), .DEPTH(MAX_PAIRS)) u_pos_ram (
    .clk     (clk),
    .we      (dist_we && s2_pos),
    .waddr   (np[PADDR_W-1:0]),
    .wdata   (acc_sum),
    .raddr_a (sidx[PADDR_W-1:0]),
    .raddr_b (sidx[PADDR_W-1:0]),
    .rdata_a (pos_rd),
    .rdata_b ()
  );

  hpcl_ram #(.WIDTH(DIST_W), .DEPTH(MAX_PAIRS)) u_neg_ram (
    .clk     (clk),
    .we      (dist_we && !s2_pos),
    .waddr   (nn[PADDR_W-1:0]),
    .wdata   (acc_sum),
    .raddr_a (sidx[PADDR_W-1:0]),
    .raddr_b (sidx[PADDR_W-1:0]),
    .rdata_a (neg_rd),
    .rdata_b ()
  );

  // ---------------------------------------------------------------- root chain
  sqc_ctl_t          ch_ctl  [RW+1];
  logic [REM_W-1:0]  ch_rem  [RW+1];
  logic [RW-1:0]     ch_root [RW+1];
  logic [RADP_W-1:0] ch_rad  [RW+1];
  logic              neg_in, push, push_tag;
  logic [DIST_W-1:0] push_val;

  always_comb begin
    neg_in   = (state == ST_SUM) && rv_valid && rv_n && (neg_rd < tn);
    push     = (neg_in && !legacy_mode) || (state == ST_TAIL);
    push_tag = (state == ST_TAIL);
    push_val = (state == ST_TAIL) ? tn : neg_rd;
  end

  assign ch_ctl[0]  = '{valid: push, tag: push_tag};
  assign ch_rem[0]  = '0;
  assign ch_root[0] = '0;
  assign ch_rad[0]  = RADP_W'({push_val, 16'b0});

  for (genvar g = 0; g < RW; g++) begin : g_root
    hpcl_sqrt_cell #(.RW(RW), .RADP_W(RADP_W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_ctl   (ch_ctl[g]),
      .in_rem   (ch_rem[g]),
      .in_root  (ch_root[g]),
      .in_rad   (ch_rad[g]),
      .out_ctl  (ch_ctl[g+1]),
      .out_rem  (ch_rem[g+1]),
      .out_root (ch_root[g+1]),
      .out_rad  (ch_rad[g+1])
    );
  end

  // hinge stages after the chain: margin - root, then the square
  sqc_ctl_t            h_ctl, m_ctl;
  logic [MARGIN_W-1:0] h_val;
  logic [SUM_W-1:0]    m_val;
  logic [LOSS_W-1:0]   fthr;

  // ---------------------------------------------------------------- totals
  logic [KW+DIST_W-1:0] prod_p;
  logic [KW+LOSS_W-1:0] prod_n;
  logic [KW:0]          kpn;
  logic [DV_W-1:0]      dvsr, drem;
  logic [DV_W:0]        r2;
  logic                 qbit, fault_c;
  logic [SUM_W-1:0]     dq;
  logic [DC_W-1:0]      dcnt;

  always_comb begin
    kpn     = {1'b0, kp} + {1'b0, kn};
    dvsr    = {kpn, 1'b0};
    fault_c = (num_r < SAMP_W'(2)) || (kpn == '0);
    r2      = {drem, dq[SUM_W-1]};
    qbit    = (r2 >= {1'b0, dvsr});
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      sc       <= '0;
      cc       <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      rv_valid <= 1'b0;
      h_ctl    <= '0;
      m_ctl    <= '0;
      result_valid <= 1'b0;
    end else begin
      s1_valid <= (state == ST_DIST);
      s2_valid <= s1_valid;
      h_ctl    <= ch_ctl[RW];
      m_ctl    <= h_ctl;

      unique case (state)
        ST_LOAD: begin
          if (item_accept) begin
            if (ld_write && ld_close) begin
              last_len <= cc1;
            end
            if (batch_end) begin
              num_r <= (ld_write && ld_close) ? sc0 + 1'b1 : sc0;
              sc    <= '0;
              cc    <= '0;
              np    <= '0;
              nn    <= '0;
              pi    <= '0;
              pj    <= SIDX_W'(1);
              pc    <= '0;
              // fewer than two samples: no pairs at all
              if (((ld_write && ld_close) ? sc0 + 1'b1 : sc0) < SAMP_W'(2)) begin
                state <= ST_DRAIN;
              end else begin
                state <= ST_DIST;
              end
            end else if (ld_write && ld_close) begin
              cc <= '0;
              sc <= sc0 + 1'b1;
            end else if (ld_write) begin
              cc <= cc1;
              sc <= sc0;
            end else begin
              cc <= cc0;
              sc <= sc0;
            end
          end
        end
        ST_DIST: begin
          if (dist_last_c) begin
            pc <= '0;
            if (j_last) begin
              if (i_last) begin
                state <= ST_DRAIN;
              end else begin
                pi <= pi + 1'b1;
                pj <= SIDX_W'(pi + 2'd2);
              end
            end else begin
              pj <= pj + 1'b1;
            end
          end else begin
            pc <= pc + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (!s1_valid && !s2_valid) begin
            kp     <= (KW'(np) < KW'(hard_pos)) ? KW'(np) : KW'(hard_pos);
            kn     <= (KW'(nn) < KW'(hard_neg)) ? KW'(nn) : KW'(hard_neg);
            scan_n <= (np > nn) ? np : nn;
            sb     <= SB_W'(DIST_W - 1);
            tp     <= '0;
            tn     <= '0;
            sidx   <= '0;
            cnt_p  <= '0;
            cnt_n  <= '0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN, ST_SUM: begin
          if (sidx < scan_n) begin
            rv_valid <= 1'b1;
            rv_p     <= (sidx < np);
            rv_n     <= (sidx < nn);
            sidx     <= sidx + 1'b1;
          end else begin
            rv_valid <= 1'b0;
            state    <= (state == ST_SCAN) ? ST_DECIDE : ST_TAIL;
          end
        end
        ST_DECIDE: begin
          if (KW'(cnt_p) >= kp) begin
            tp <= tp | bitmask;
          end
          if (KW'(cnt_n) < kn) begin
            tn <= tn | bitmask;
          end
          cnt_p <= '0;
          cnt_n <= '0;
          sidx  <= '0;
          if (sb == '0) begin
            sum_p <= '0;
            sum_n <= '0;
            cgt_p <= '0;
            cgt_n <= '0;
            state <= ST_SUM;
          end else begin
            sb    <= sb - 1'b1;
            state <= ST_SCAN;
          end
        end
        ST_TAIL: begin
          state <= ST_HINGE;
        end
        ST_HINGE: begin
          if (m_ctl.valid && m_ctl.tag) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_p <= (kp - KW'(cgt_p)) * tp;
          prod_n <= (kn - KW'(cgt_n)) * fthr;
          state  <= ST_TOTAL;
        end
        ST_TOTAL: begin
          drem <= '0;
          dcnt <= '0;
          if (fault_c) begin
            dq    <= '0;
            state <= ST_DONE;
          end else begin
            dq    <= sum_p + sum_n + SUM_W'(prod_p) + SUM_W'(prod_n);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          drem <= qbit ? DV_W'(r2 - {1'b0, dvsr}) : DV_W'(r2);
          dq   <= {dq[SUM_W-2:0], qbit};
          dcnt <= dcnt + 1'b1;
          if (dcnt == DC_W'(SUM_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!result_valid || !result_stall) begin
            state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase

      // result beat: raised from the done step, dropped once taken
      if (state == ST_DONE && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      // pair counts advance as each distance is written
      if (dist_we) begin
        if (s2_pos) begin
          np <= np + 1'b1;
        end else begin
          nn <= nn + 1'b1;
        end
      end

      // counting and summing on the data returned by the previous sweep read
      if (state == ST_SCAN && rv_valid) begin
        if (rv_p && (pos_rd >= cand_p)) begin
          cnt_p <= cnt_p + 1'b1;
        end
        if (rv_n && (neg_rd <= cand_n)) begin
          cnt_n <= cnt_n + 1'b1;
        end
      end
      if (state == ST_SUM && rv_valid) begin
        if (rv_p && (pos_rd > tp)) begin
          sum_p <= sum_p + SUM_W'(pos_rd);
          cgt_p <= cgt_p + 1'b1;
        end
        if (neg_in) begin
          cgt_n <= cgt_n + 1'b1;
        end
      end
      if (neg_in && legacy_mode) begin
        if (margin_ext > neg_rd) begin
          sum_n <= sum_n + SUM_W'(margin_ext - neg_rd);
        end
      end else if (m_ctl.valid && !m_ctl.tag) begin
        sum_n <= sum_n + SUM_W'(m_val[SUM_W-1:16]);
      end
    end
  end

  // distance datapath, hinge stages and result payload
  always_ff @(posedge clk) begin
    s1_first <= (pc == '0);
    s1_last  <= dist_last_c;
    s1_mask  <= j_last && (DIMC_W'(pc) >= last_len);
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_pos   <= (lab_a == lab_b);
    s2_sq    <= sq_full[31:0];
    if (s2_valid) begin
      acc <= acc_sum;
    end

    h_val <= ({1'b0, margin} > (MARGIN_W + 1)'(ch_root[RW])) ?
             MARGIN_W'(margin - MARGIN_W'(ch_root[RW])) : '0;
    m_val <= SUM_W'(h_val) * SUM_W'(h_val);
    if (m_ctl.valid && m_ctl.tag) begin
      if (legacy_mode) begin
        fthr <= (margin_ext > tn) ? LOSS_W'(margin_ext - tn) : '0;
      end else begin
        fthr <= m_val[SUM_W-1:16];
      end
    end

    if (state == ST_DONE && (!result_valid || !result_stall)) begin
      loss     <= (|dq[SUM_W-1:LOSS_W]) ? '1 : dq[LOSS_W-1:0];
      pos_kept <= kp[KEPT_W-1:0];
      neg_kept <= kn[KEPT_W-1:0];
      fault    <= fault_c;
    end
  end

  // ---------------------------------------------------------------- checks
  a_sample_bound: assert property (@(posedge clk) disable iff (rst)
    sc <= SAMP_W'(MAX_SAMPLES))
    else $error("sample count beyond MAX_SAMPLES");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && fault |-> loss == '0)
    else $error("fault result with nonzero loss");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_DONE))
    else $error("result beat raised outside the done step");

  a_mul_after_tag: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> $past(m_ctl.valid && m_ctl.tag))
    else $error("totals started before the threshold hinge arrived");

endmodule
